// ===== rtl/core/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg - shared types and helpers for the seven-segment clock
// Item kinds, key state records, digit patterns and time arithmetic.
// ----------------------------------------------------------------------------
package ccs_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_KEYS = 2'd1,
        KIND_SCAN = 2'd2
    } ccs_kind_t;

    localparam logic [7:0] DASH_PATTERN  = 8'h40;
    localparam logic [7:0] BLANK_PATTERN = 8'h00;
    localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
    localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
    localparam logic [4:0] TEN_HOURS        = 5'd10;

    localparam logic [7:0] DIGIT_PATTERN [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct packed {
        logic       latched;
        logic [1:0] count;
    } ccs_key_t;

    typedef struct packed {
        ccs_key_t state;
        logic     hit_hour;
        logic     hit_minute;
        logic     hit_second;
    } ccs_key_upd_t;

    function automatic logic [7:0] digit_pattern(input logic [3:0] d);
        return (d < 4'd10) ? DIGIT_PATTERN[d] : BLANK_PATTERN;
    endfunction

    // v / 10 by reciprocal, exact for v < 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [13:0] p;
        p = 14'(v) * 14'd205;
        return p[13:11];
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t;
        t = v - 6'(tens_of(v)) * 6'd10;
        return t[3:0];
    endfunction

    function automatic logic [4:0] bump_hour(input logic [4:0] v);
        logic [5:0] n;
        n = {1'b0, v} + 6'd1;
        return (n >= HOURS_PER_DAY) ? 5'd0 : n[4:0];
    endfunction

    function automatic logic [5:0] bump_sixty(input logic [5:0] v);
        logic [6:0] n;
        n = {1'b0, v} + 7'd1;
        return (n >= MINUTES_PER_HOUR) ? 6'd0 : n[5:0];
    endfunction

endpackage

// ===== rtl/core/clock_seven_segment_scan_and_set.sv =====
// ----------------------------------------------------------------------------
// clock_seven_segment_scan_and_set - multiplexed seven-segment clock display
// Holds the time, scans eight digit positions and sets the time from keys or the RTC.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one request per event. s_tuser is the kind (load time from
//   the RTC, key sample, scan tick); s_tdata carries key levels and RTC time.
//   Master channel: exactly one result per request, giving the digit address
//   and segment pattern on scan ticks, the set-time / LED strobes on an
//   accepted key press, and the held time after the request.
//   The request waits in the input register and is processed into the result
//   register, which drives m_tvalid. Throughput is one request per cycle
//   while the receiver does not stall; the held time is updated as each
//   request moves into the result register, so the next request already
//   sees it.
//   Reset clears the time, the debounce state and the scan position, and
//   empties both registers. When the receiver stalls, the result is held and
//   one further request is taken into the input register before s_tready
//   drops.
// ----------------------------------------------------------------------------
module clock_seven_segment_scan_and_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] key_hour, [1] key_minute, [2] key_second, [3] key_spare,
    // [8:4] hour_in, [14:9] minute_in, [20:15] second_in
    input  logic [23:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] digit_select, [10:3] segments, [11] set_time, [16:12] hour_out,
    // [22:17] minute_out, [28:23] second_out, [29] led_toggle
    output logic [31:0] m_tdata
);

    logic              in_valid_reg;
    ccs_pkg::ccs_kind_t in_kind_reg;
    logic [3:0]        in_keys_reg;
    logic [4:0]        in_hour_reg;
    logic [5:0]        in_minute_reg;
    logic [5:0]        in_second_reg;

    logic [4:0]        hours_reg,   hours_next;
    logic [5:0]        minutes_reg, minutes_next;
    logic [5:0]        seconds_reg, seconds_next;
    logic [2:0]        pos_reg,     pos_next;
    ccs_pkg::ccs_key_t key_reg,     key_next;

    logic              out_valid_reg;
    logic [2:0]        out_sel_reg;
    logic [7:0]        out_seg_reg;
    logic              out_set_reg;
    logic [4:0]        out_hour_reg;
    logic [5:0]        out_minute_reg;
    logic [5:0]        out_second_reg;

    logic                  step;
    logic                  changed;
    logic [7:0]            scan_seg;
    logic [7:0]            seg_next;
    ccs_pkg::ccs_key_upd_t key_upd;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    ccs_key_debounce u_keys (
        .key_state  (key_reg),
        .key_hour   (in_keys_reg[0]),
        .key_minute (in_keys_reg[1]),
        .key_second (in_keys_reg[2]),
        .key_spare  (in_keys_reg[3]),
        .key_upd    (key_upd)
    );

    ccs_seg_select u_seg (
        .position (pos_reg),
        .hours    (hours_reg),
        .minutes  (minutes_reg),
        .seconds  (seconds_reg),
        .segments (scan_seg)
    );

    always_comb begin
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        changed      = 1'b0;
        seg_next     = ccs_pkg::BLANK_PATTERN;
        unique case (in_kind_reg)
            ccs_pkg::KIND_LOAD: begin
                hours_next   = in_hour_reg;
                minutes_next = in_minute_reg;
                seconds_next = in_second_reg;
            end
            ccs_pkg::KIND_KEYS: begin
                key_next = key_upd.state;
                changed  = key_upd.hit_hour || key_upd.hit_minute || key_upd.hit_second;
                if (key_upd.hit_hour) begin
                    hours_next = ccs_pkg::bump_hour(hours_reg);
                end
                if (key_upd.hit_minute) begin
                    minutes_next = ccs_pkg::bump_sixty(minutes_reg);
                end
                if (key_upd.hit_second) begin
                    seconds_next = ccs_pkg::bump_sixty(seconds_reg);
                end
            end
            ccs_pkg::KIND_SCAN: begin
                seg_next = scan_seg;
                pos_next = pos_reg + 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hours_reg     <= '0;
            minutes_reg   <= '0;
            seconds_reg   <= '0;
            pos_reg       <= '0;
            key_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
                hours_reg     <= hours_next;
                minutes_reg   <= minutes_next;
                seconds_reg   <= seconds_next;
                pos_reg       <= pos_next;
                key_reg       <= key_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg   <= ccs_pkg::ccs_kind_t'(s_tuser);
            in_keys_reg   <= s_tdata[3:0];
            in_hour_reg   <= s_tdata[8:4];
            in_minute_reg <= s_tdata[14:9];
            in_second_reg <= s_tdata[20:15];
        end
        if (step) begin
            out_sel_reg    <= pos_reg;
            out_seg_reg    <= seg_next;
            out_set_reg    <= changed;
            out_hour_reg   <= hours_next;
            out_minute_reg <= minutes_next;
            out_second_reg <= seconds_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_set_reg, out_second_reg, out_minute_reg, out_hour_reg,
                       out_set_reg, out_seg_reg, out_sel_reg};

    a_latched_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        key_reg.latched |-> (key_reg.count == 2'd0))
        else $error("debounce count left non-zero while press latched");

    a_count_below_two: assert property (@(posedge aclk) disable iff (!aresetn)
        !key_reg.count[1])
        else $error("debounce count passed acceptance threshold");

    a_scan_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (pos_reg != $past(pos_reg)))
            |-> $past(step && (in_kind_reg == ccs_pkg::KIND_SCAN)))
        else $error("scan position moved without a scan tick");

    a_press_no_segments: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_set_reg) |-> (out_seg_reg == ccs_pkg::BLANK_PATTERN))
        else $error("segments driven on a key press result");

endmodule

// ===== rtl/core/ccs_key_debounce.sv =====
// ----------------------------------------------------------------------------
// ccs_key_debounce - shared-count key press qualifier
// Checks hour, minute and second keys in order against one debounce count.
// ----------------------------------------------------------------------------
module ccs_key_debounce (
    input  ccs_pkg::ccs_key_t     key_state,
    input  logic                  key_hour,
    input  logic                  key_minute,
    input  logic                  key_second,
    input  logic                  key_spare,
    output ccs_pkg::ccs_key_upd_t key_upd
);

    typedef struct packed {
        ccs_pkg::ccs_key_t state;
        logic              hit;
    } step_t;

    function automatic step_t check_key(input ccs_pkg::ccs_key_t s, input logic level);
        step_t r;
        r.state = s;
        r.hit   = 1'b0;
        if (!level && !s.latched) begin
            r.state.count = s.count + 2'd1;
            if (r.state.count > 2'd1) begin
                r.state.latched = 1'b1;
                r.state.count   = 2'd0;
                r.hit           = 1'b1;
            end
        end
        return r;
    endfunction

    step_t s_hour;
    step_t s_minute;
    step_t s_second;

    always_comb begin
        s_hour   = check_key(key_state, key_hour);
        s_minute = check_key(s_hour.state, key_minute);
        s_second = check_key(s_minute.state, key_second);

        key_upd.state      = s_second.state;
        key_upd.hit_hour   = s_hour.hit;
        key_upd.hit_minute = s_minute.hit;
        key_upd.hit_second = s_second.hit;
        // all four released
        if (key_hour && key_minute && key_second && key_spare) begin
            key_upd.state.latched = 1'b0;
            key_upd.state.count   = 2'd0;
        end
    end

endmodule

// ===== rtl/core/ccs_seg_select.sv =====
// ----------------------------------------------------------------------------
// ccs_seg_select - segment pattern for one scan position
// Splits the held time into digits and picks the pattern for a position.
// ----------------------------------------------------------------------------
module ccs_seg_select (
    input  logic [2:0] position,
    input  logic [4:0] hours,
    input  logic [5:0] minutes,
    input  logic [5:0] seconds,
    output logic [7:0] segments
);

    always_comb begin
        unique case (position)
            3'd0: segments = ccs_pkg::digit_pattern(ccs_pkg::units_of(seconds));
            3'd1: segments = ccs_pkg::digit_pattern({1'b0, ccs_pkg::tens_of(seconds)});
            3'd2: segments = ccs_pkg::DASH_PATTERN;
            3'd3: segments = ccs_pkg::digit_pattern(ccs_pkg::units_of(minutes));
            3'd4: segments = ccs_pkg::digit_pattern({1'b0, ccs_pkg::tens_of(minutes)});
            3'd5: segments = ccs_pkg::DASH_PATTERN;
            3'd6: segments = ccs_pkg::digit_pattern(ccs_pkg::units_of({1'b0, hours}));
            default: begin
                segments = (hours >= ccs_pkg::TEN_HOURS)
                         ? ccs_pkg::digit_pattern({1'b0, ccs_pkg::tens_of({1'b0, hours})})
                         : ccs_pkg::BLANK_PATTERN;
            end
        endcase
    end

endmodule
